@@ design/jkse_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON key string extractor package
// Shared constants, result codes and control structs for the extractor.
// ----------------------------------------------------------------------------
package jkse_pkg;

  // Longest key that the needle search compares
  localparam int KEY_MAX    = 16;
  // Needle window: quote, key, quote, colon
  localparam int WIN        = KEY_MAX + 3;
  // Width of lane arithmetic over the window
  localparam int LANE_W     = $clog2(WIN + 1);

  localparam int KLEN_W     = 5;
  localparam int KCHARS_W   = 128;
  localparam int KCHARS_N   = KCHARS_W / 8;
  localparam int CAP_W      = 16;
  localparam int CNT_W      = 16;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 2'd3;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 16'd256;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_BYTE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DONE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NOKEY  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NOTSTR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BADESC = 3'd4;
  localparam logic [KIND_W-1:0] KIND_OVER   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNTERM = 3'd6;

  // Characters of interest
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [KLEN_W-1:0]   key_length;
    logic [KCHARS_W-1:0] key_chars;
    logic [CAP_W-1:0]    capacity;
  } cfg_t;

  // Window control from the parser
  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctrl_t;

  // One result of the parser
  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [7:0]        value_byte;
    logic [CNT_W-1:0]  count;
  } result_t;

  // Hex digit decode: {valid, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

@@ design/jkse_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON key string extractor channels
// Valid/ready channels for text bytes and for results.
// ----------------------------------------------------------------------------
interface jkse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, text_byte, last_byte, input ready);
  modport sink   (input valid, text_byte, last_byte, output ready);
endinterface

interface jkse_out_if;
  logic                        valid;
  logic                        ready;
  logic [jkse_pkg::KIND_W-1:0] kind;
  logic [7:0]                  value_byte;
  logic [jkse_pkg::CNT_W-1:0]  count;

  modport source (output valid, kind, value_byte, count, input ready);
  modport sink   (input valid, kind, value_byte, count, output ready);
endinterface

@@ design/jkse_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Holds key length, key characters and output capacity.
// ----------------------------------------------------------------------------
module jkse_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [jkse_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jkse_pkg::CFG_DATA_W-1:0]     cfg_data,
  output jkse_pkg::cfg_t                      cfg
);

  logic [jkse_pkg::KLEN_W-1:0]     key_length_r;
  logic [jkse_pkg::CFG_DATA_W-1:0] key_low_r;
  logic [jkse_pkg::CFG_DATA_W-1:0] key_high_r;
  logic [jkse_pkg::CAP_W-1:0]      capacity_r;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= '0;
      key_low_r    <= '0;
      key_high_r   <= '0;
      capacity_r   <= jkse_pkg::CAPACITY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        jkse_pkg::CFG_KEY_LENGTH: key_length_r <= cfg_data[jkse_pkg::KLEN_W-1:0];
        jkse_pkg::CFG_KEY_LOW:    key_low_r    <= cfg_data;
        jkse_pkg::CFG_KEY_HIGH:   key_high_r   <= cfg_data;
        jkse_pkg::CFG_CAPACITY:   capacity_r   <= cfg_data[jkse_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.key_length = key_length_r;
  assign cfg.key_chars  = {key_high_r, key_low_r};
  assign cfg.capacity   = capacity_r;

endmodule

@@ design/jkse_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Needle window
// Shift register of recent text bytes and the quote-key-quote-colon compare.
// ----------------------------------------------------------------------------
module jkse_window (
  input  logic                clk,
  input  logic                rst_n,
  input  jkse_pkg::cfg_t      cfg,
  input  logic [7:0]          text_byte,
  input  jkse_pkg::win_ctrl_t ctrl,
  output logic                match
);

  // Entry 0 is the newest byte
  logic [7:0] window_r [jkse_pkg::WIN];
  logic [7:0] view     [jkse_pkg::WIN];
  logic [jkse_pkg::LANE_W-1:0] klen;
  logic [jkse_pkg::WIN-1:0]    lane_ok;

  function automatic logic [7:0] key_char(input logic [jkse_pkg::KCHARS_W-1:0] chars,
                                          input logic [jkse_pkg::LANE_W-1:0] idx);
    logic [7:0] r;
    r = 8'h00;
    if (32'(idx) < jkse_pkg::KCHARS_N) begin
      r = chars[8*idx[$clog2(jkse_pkg::KCHARS_N)-1:0] +: 8];
    end
    return r;
  endfunction

  // Saturate key length
  always_comb begin
    if (32'(cfg.key_length) > jkse_pkg::KEY_MAX) begin
      klen = jkse_pkg::LANE_W'(jkse_pkg::KEY_MAX);
    end else begin
      klen = jkse_pkg::LANE_W'(cfg.key_length);
    end
  end

  // Window as it stands after taking the current byte
  always_comb begin
    view[0] = text_byte;
    for (int j = 1; j < jkse_pkg::WIN; j++) begin
      view[j] = window_r[j-1];
    end
  end

  // Compare each lane against its expected character
  always_comb begin
    logic [jkse_pkg::LANE_W-1:0] jj;
    for (int j = 0; j < jkse_pkg::WIN; j++) begin
      jj = jkse_pkg::LANE_W'(j);
      if (j == 0) begin
        lane_ok[j] = (view[j] == jkse_pkg::CH_COLON);
      end else if (j == 1 || jj == klen + jkse_pkg::LANE_W'(2)) begin
        lane_ok[j] = (view[j] == jkse_pkg::CH_QUOTE);
      end else if (jj <= klen + jkse_pkg::LANE_W'(1)) begin
        lane_ok[j] = (view[j] ==
                      key_char(cfg.key_chars, klen + jkse_pkg::LANE_W'(1) - jj));
      end else begin
        lane_ok[j] = 1'b1;
      end
    end
  end

  // Unseen entries hold zero, so a short history fails the leading quote
  assign match = &lane_ok;

  // Shift in on search bytes, clear when searching restarts
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      for (int j = 0; j < jkse_pkg::WIN; j++) window_r[j] <= 8'h00;
    end else if (ctrl.shift) begin
      for (int j = 0; j < jkse_pkg::WIN; j++) window_r[j] <= view[j];
    end
  end

endmodule

@@ design/jkse_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Value parser
// Phase sequencing, escape and hex decode, capacity check and result codes.
// ----------------------------------------------------------------------------
module jkse_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       advance,
  input  logic [7:0]                 text_byte,
  input  logic                       last_byte,
  input  logic                       match,
  input  logic [jkse_pkg::CAP_W-1:0] capacity,
  output jkse_pkg::win_ctrl_t        win_ctrl,
  output jkse_pkg::result_t          result
);

  localparam logic [2:0] PH_SEARCH = 3'd0;
  localparam logic [2:0] PH_SPACE  = 3'd1;
  localparam logic [2:0] PH_STR    = 3'd2;
  localparam logic [2:0] PH_ESC    = 3'd3;
  localparam logic [2:0] PH_HEX    = 3'd4;
  localparam logic [2:0] PH_IGNORE = 3'd5;

  logic [2:0]                 phase_r,     phase_nxt;
  logic [2:0]                 hex_left_r,  hex_left_nxt;
  logic [7:0]                 hex_byte_r,  hex_byte_nxt;
  logic [jkse_pkg::CNT_W-1:0] out_count_r, out_count_nxt;

  logic                        fin, em, restart;
  logic [jkse_pkg::KIND_W-1:0] fin_kind;
  logic [jkse_pkg::CNT_W-1:0]  fin_cnt;
  logic [7:0]                  em_byte;
  logic [4:0]                  hv;
  logic [7:0]                  hb;
  logic [2:0]                  hl;

  assign hv = jkse_pkg::hex_value(text_byte);
  assign hb = {hex_byte_r[3:0], hv[3:0]};
  assign hl = (hex_left_r != 3'd0) ? hex_left_r - 3'd1 : hex_left_r;

  always_comb begin
    phase_nxt     = phase_r;
    hex_left_nxt  = hex_left_r;
    hex_byte_nxt  = hex_byte_r;
    out_count_nxt = out_count_r;
    fin      = 1'b0;
    fin_kind = jkse_pkg::KIND_DONE;
    fin_cnt  = out_count_r;
    em       = 1'b0;
    em_byte  = text_byte;
    restart  = 1'b0;
    result   = '0;

    // Decide what this byte does in the current phase
    case (phase_r)
      PH_SEARCH: begin
        if (match) begin
          if (last_byte) begin
            fin = 1'b1; fin_kind = jkse_pkg::KIND_NOTSTR; fin_cnt = '0;
          end else begin
            phase_nxt = PH_SPACE;
          end
        end else if (last_byte) begin
          fin = 1'b1; fin_kind = jkse_pkg::KIND_NOKEY; fin_cnt = '0;
        end
      end
      PH_SPACE: begin
        if (text_byte == jkse_pkg::CH_SPACE || text_byte == jkse_pkg::CH_TAB) begin
          if (last_byte) begin
            fin = 1'b1; fin_kind = jkse_pkg::KIND_NOTSTR; fin_cnt = '0;
          end
        end else if (text_byte != jkse_pkg::CH_QUOTE) begin
          fin = 1'b1; fin_kind = jkse_pkg::KIND_NOTSTR; fin_cnt = '0;
        end else begin
          out_count_nxt = '0;
          if (last_byte) begin
            fin = 1'b1; fin_kind = jkse_pkg::KIND_UNTERM; fin_cnt = '0;
          end else begin
            phase_nxt = PH_STR;
          end
        end
      end
      PH_STR: begin
        if (text_byte == jkse_pkg::CH_QUOTE) begin
          fin = 1'b1;
          fin_kind = (capacity == '0) ? jkse_pkg::KIND_OVER : jkse_pkg::KIND_DONE;
        end else if (text_byte == jkse_pkg::CH_BSLASH) begin
          if (last_byte) begin
            fin = 1'b1; fin_kind = jkse_pkg::KIND_BADESC;
          end else begin
            phase_nxt = PH_ESC;
          end
        end else begin
          em = 1'b1;
        end
      end
      PH_ESC: begin
        case (text_byte)
          jkse_pkg::CH_QUOTE, jkse_pkg::CH_BSLASH, jkse_pkg::CH_SLASH: em = 1'b1;
          8'h6e: begin em = 1'b1; em_byte = 8'h0a; end
          8'h72: begin em = 1'b1; em_byte = 8'h0d; end
          8'h74: begin em = 1'b1; em_byte = 8'h09; end
          8'h62: begin em = 1'b1; em_byte = 8'h08; end
          8'h66: begin em = 1'b1; em_byte = 8'h0c; end
          8'h75: begin
            if (last_byte) begin
              fin = 1'b1; fin_kind = jkse_pkg::KIND_BADESC;
            end else begin
              hex_left_nxt = 3'd4;
              hex_byte_nxt = 8'h00;
              phase_nxt    = PH_HEX;
            end
          end
          default: begin
            fin = 1'b1; fin_kind = jkse_pkg::KIND_BADESC;
          end
        endcase
      end
      PH_HEX: begin
        if (!hv[4]) begin
          fin = 1'b1; fin_kind = jkse_pkg::KIND_BADESC;
        end else begin
          hex_byte_nxt = hb;
          hex_left_nxt = hl;
          if (hl == 3'd0) begin
            em = 1'b1; em_byte = hb;
          end else if (last_byte) begin
            fin = 1'b1; fin_kind = jkse_pkg::KIND_BADESC;
          end
        end
      end
      default: begin
        restart = last_byte;
      end
    endcase

    // Emit a decoded byte unless capacity or end of text forbids it
    if (em) begin
      if ({1'b0, out_count_r} + 17'd1 >= {1'b0, capacity}) begin
        fin = 1'b1; fin_kind = jkse_pkg::KIND_OVER;
      end else if (last_byte) begin
        fin = 1'b1; fin_kind = jkse_pkg::KIND_UNTERM;
      end else begin
        out_count_nxt     = out_count_r + jkse_pkg::CNT_W'(1);
        phase_nxt         = PH_STR;
        result.valid      = 1'b1;
        result.kind       = jkse_pkg::KIND_BYTE;
        result.value_byte = em_byte;
        result.count      = out_count_r + jkse_pkg::CNT_W'(1);
      end
    end

    // Final result: restart at end of text, else drop bytes until then
    if (fin) begin
      result.valid      = 1'b1;
      result.kind       = fin_kind;
      result.value_byte = 8'h00;
      result.count      = fin_cnt;
      if (last_byte) begin
        restart = 1'b1;
      end else begin
        phase_nxt = PH_IGNORE;
      end
    end

    if (restart) begin
      phase_nxt     = PH_SEARCH;
      hex_left_nxt  = '0;
      hex_byte_nxt  = '0;
      out_count_nxt = '0;
    end
  end

  assign win_ctrl.shift = advance && (phase_r == PH_SEARCH);
  assign win_ctrl.clear = advance && restart;

  // Advance state once per processed transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SEARCH;
      hex_left_r  <= '0;
      hex_byte_r  <= '0;
      out_count_r <= '0;
    end else if (advance) begin
      phase_r     <= phase_nxt;
      hex_left_r  <= hex_left_nxt;
      hex_byte_r  <= hex_byte_nxt;
      out_count_r <= out_count_nxt;
    end
  end

endmodule

@@ design/json_key_string_extractor_core.sv @@
`timescale 1ns / 1ps
// Path: an accepted byte passes the input register, then the result register;
//   bytes that cause no result leave none.
// Throughput: one byte per cycle while results are taken; a held result
//   stalls the input register, which still takes one more byte.
// Reset: synchronous active-low; clears phase, window, counters and valid
//   flags, and loads the configuration defaults (capacity 256, empty key).
// ----------------------------------------------------------------------------
// JSON key string extractor core
// Finds a quoted key followed by a colon and streams its decoded string value.
// ----------------------------------------------------------------------------
module json_key_string_extractor_core (
  input  logic                            clk,
  input  logic                            rst_n,
  jkse_in_if.sink                         in_chan,
  jkse_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [jkse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jkse_pkg::CFG_DATA_W-1:0] cfg_data
);

  jkse_pkg::cfg_t      cfg;
  jkse_pkg::win_ctrl_t win_ctrl;
  jkse_pkg::result_t   result;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       advance;
  logic       match;

  logic                          out_valid_r;
  logic [jkse_pkg::KIND_W-1:0]   out_kind_r;
  logic [7:0]                    out_byte_r;
  logic [jkse_pkg::CNT_W-1:0]    out_count_r;

  // Process the held byte when the result register can take its outcome
  assign advance       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || advance;

  jkse_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  jkse_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .text_byte (s1_byte_r),
    .ctrl      (win_ctrl),
    .match     (match)
  );

  jkse_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .text_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .match     (match),
    .capacity  (cfg.capacity),
    .win_ctrl  (win_ctrl),
    .result    (result)
  );

  // Input register: hold the accepted transaction until processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_byte_r <= in_chan.text_byte;
      s1_last_r <= in_chan.last_byte;
    end
  end

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= result.valid;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      out_kind_r  <= result.kind;
      out_byte_r  <= result.value_byte;
      out_count_r <= result.count;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.kind       = out_kind_r;
  assign out_chan.value_byte = out_byte_r;
  assign out_chan.count      = out_count_r;

endmodule

@@ design/jkse_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extractor port checker
// Watches the result channel of the core and flags illegal behavior.
// ----------------------------------------------------------------------------
module jkse_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [jkse_pkg::KIND_W-1:0] out_kind,
  input logic [7:0]                  out_value_byte,
  input logic [jkse_pkg::CNT_W-1:0]  out_count
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_count))
    else $error("result changed while stalled");

  // No result in the cycle after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result shown right after reset");

  // Only byte results carry a value
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != jkse_pkg::KIND_BYTE |-> out_value_byte == 8'h00)
    else $error("non-byte result carries a value");

  // Byte results count from one
  a_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == jkse_pkg::KIND_BYTE |-> out_count != '0)
    else $error("byte result with zero count");

  // Search failures report zero count
  a_search_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == jkse_pkg::KIND_NOKEY || out_kind == jkse_pkg::KIND_NOTSTR)
      |-> out_count == '0)
    else $error("search failure with nonzero count");

endmodule

bind json_key_string_extractor_core jkse_checker u_jkse_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_kind       (out_chan.kind),
  .out_value_byte (out_chan.value_byte),
  .out_count      (out_chan.count)
);
